@@ hw/rtl/cfmg_pkg.sv @@
// ----------------------------------------------------------------------------
// cfmg_pkg
// shared types, verdict codes and the fixed action table of the frame guard
// ----------------------------------------------------------------------------
package cfmg_pkg;

    localparam int MAX_FRAME_BYTES = 8;
    localparam int ROW_COUNT       = 11;
    localparam int ACTION_W        = 4;
    localparam int ID_W            = 29;
    localparam int DLC_W           = 4;
    localparam int DATA_W          = 8 * MAX_FRAME_BYTES;
    localparam int MS_W            = 32;
    localparam int FRESH_W         = 16;
    localparam int VERDICT_W       = 4;
    localparam int ROW_ID_W        = 11;

    localparam logic [FRESH_W-1:0] FRESH_RESET = 16'd500;

    // apb
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_FRESH_MS = 1'b0;

    // stream payload widths, padded to whole bytes
    localparam int IN_FIELDS_W = ID_W + DATA_W + DLC_W + 1 + DATA_W + DLC_W + MS_W + MS_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((VERDICT_W + 7) / 8) * 8;

    typedef enum logic [VERDICT_W-1:0] {
        V_OK          = 4'd0,
        V_NO_ROW      = 4'd1,
        V_BAD_ARGS    = 4'd2,
        V_WRONG_ID    = 4'd3,
        V_WRONG_LEN   = 4'd4,
        V_WRONG_MUX   = 4'd5,
        V_NO_REF      = 4'd6,
        V_STALE       = 4'd7,
        V_REF_MUX     = 4'd8,
        V_OUT_OF_MASK = 4'd9
    } t_verdict;

    typedef struct packed {
        logic [MS_W-1:0]     now_ms;
        logic [MS_W-1:0]     ref_ms;
        logic [DLC_W-1:0]    ref_dlc;
        logic [DATA_W-1:0]   ref_data;
        logic                ref_seen;
        logic [DLC_W-1:0]    out_dlc;
        logic [DATA_W-1:0]   out_data;
        logic [ID_W-1:0]     can_id;
        logic [ACTION_W-1:0] action;
    } t_frame;

    typedef struct packed {
        logic [ROW_ID_W-1:0] id;
        logic [DLC_W-1:0]    len;
        logic [7:0]          mplx_mask;
        logic [7:0]          mplx_value;
        logic [DATA_W-1:0]   frozen;   // bits that must match the reference
    } t_row;

    function automatic t_row make_row(logic [ROW_ID_W-1:0] id, logic [DLC_W-1:0] len,
                                      logic [7:0] mmask, logic [7:0] mval,
                                      logic [DATA_W-1:0] payload);
        t_row              r;
        logic [DATA_W-1:0] lmask;
        if (len >= DLC_W'(MAX_FRAME_BYTES)) begin
            lmask = '1;
        end else begin
            lmask = (DATA_W'(1) << {len, 3'b000}) - DATA_W'(1);
        end
        r.id         = id;
        r.len        = len;
        r.mplx_mask  = mmask;
        r.mplx_value = mval;
        r.frozen     = ~payload & lmask;
        return r;
    endfunction

    // action table, rows without multiplex carry mask and value zero
    function automatic t_row row_of(logic [ACTION_W-1:0] action);
        t_row r;
        case (action)
            4'd0:    r = make_row(11'h273, 4'd8, 8'h00, 8'h00, 64'h0800000000000000);
            4'd1:    r = make_row(11'h1F9, 4'd8, 8'h00, 8'h00, 64'h000000000000DB60);
            4'd2:    r = make_row(11'h3C2, 4'd8, 8'hFF, 8'h29, 64'h0008000000000000);
            4'd3:    r = make_row(11'h3C2, 4'd8, 8'hFF, 8'h00, 64'h0000000000000F00);
            4'd4:    r = make_row(11'h3C2, 4'd8, 8'hFF, 8'h00, 64'h0000000000000000);
            4'd5:    r = make_row(11'h3C2, 4'd8, 8'hFF, 8'h29, 64'h000000003F000000);
            4'd6:    r = make_row(11'h229, 4'd3, 8'h00, 8'h00, 64'h000000000000FFFF);
            4'd7:    r = make_row(11'h3E9, 4'd8, 8'h00, 8'h00, 64'hFFF0000000000004);
            4'd8:    r = make_row(11'h273, 4'd8, 8'h00, 8'h00, 64'h0000000003000000);
            4'd9:    r = make_row(11'h3C2, 4'd8, 8'h03, 8'h00, 64'h0000000000000004);
            4'd10:   r = make_row(11'h249, 4'd4, 8'h00, 8'h00, 64'h00000000000EFFFF);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/cfmg_cfg.sv @@
// ----------------------------------------------------------------------------
// cfmg_cfg
// apb register file holding the reference freshness limit
// ----------------------------------------------------------------------------
module cfmg_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cfmg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [cfmg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [cfmg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [cfmg_pkg::FRESH_W-1:0]     o_fresh_ms
);
    import cfmg_pkg::*;

    logic               r_fresh_ms;
    logic [FRESH_W-1:0] r_fresh;
    logic [FRESH_W-1:0] n_fresh;
    logic               sel_fresh;

    assign sel_fresh = (paddr[APB_ADDR_W-1:2] == REG_FRESH_MS);
    assign pready    = 1'b1;

    always_comb begin
        n_fresh = r_fresh;
        if (psel && penable && pwrite && sel_fresh) begin
            n_fresh = pwdata[FRESH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh    <= FRESH_RESET;
            r_fresh_ms <= 1'b0;
        end else begin
            r_fresh    <= n_fresh;
            r_fresh_ms <= 1'b1;
        end
    end

    // reads of unmapped addresses return zero
    assign prdata     = sel_fresh ? {{(APB_DATA_W-FRESH_W){1'b0}}, r_fresh} : '0;
    assign o_fresh_ms = r_fresh_ms ? r_fresh : FRESH_RESET;

endmodule

@@ hw/rtl/cfmg_judge.sv @@
// ----------------------------------------------------------------------------
// cfmg_judge
// ordered checks of one frame against its table row, giving one verdict
// ----------------------------------------------------------------------------
module cfmg_judge (
    input  cfmg_pkg::t_frame                 i_frame,
    input  logic [cfmg_pkg::FRESH_W-1:0]     i_fresh_ms,
    output cfmg_pkg::t_verdict               o_verdict
);
    import cfmg_pkg::*;

    t_row            row;
    logic [MS_W-1:0] age;
    logic            no_row;
    logic            id_bad;
    logic            len_bad;
    logic            mux_bad;
    logic            stale;
    logic            ref_len_bad;
    logic            ref_mux_bad;
    logic            mask_bad;

    assign row         = row_of(i_frame.action);
    assign no_row      = (i_frame.action >= ACTION_W'(ROW_COUNT));
    assign id_bad      = (i_frame.can_id != {{(ID_W-ROW_ID_W){1'b0}}, row.id});
    assign len_bad     = (i_frame.out_dlc != row.len);
    assign mux_bad     = ((i_frame.out_data[7:0] & row.mplx_mask) != row.mplx_value);
    // wrapping age
    assign age         = i_frame.now_ms - i_frame.ref_ms;
    assign stale       = (age >= {{(MS_W-FRESH_W){1'b0}}, i_fresh_ms});
    assign ref_len_bad = (i_frame.ref_dlc != row.len);
    assign ref_mux_bad = ((i_frame.ref_data[7:0] & row.mplx_mask) != row.mplx_value);
    assign mask_bad    = ((i_frame.out_data & row.frozen) != (i_frame.ref_data & row.frozen));

    always_comb begin
        if (i_frame.out_dlc > DLC_W'(MAX_FRAME_BYTES)) begin
            o_verdict = V_BAD_ARGS;
        end else if (no_row) begin
            o_verdict = V_NO_ROW;
        end else if (id_bad) begin
            o_verdict = V_WRONG_ID;
        end else if (len_bad) begin
            o_verdict = V_WRONG_LEN;
        end else if (mux_bad) begin
            o_verdict = V_WRONG_MUX;
        end else if (!i_frame.ref_seen) begin
            o_verdict = V_NO_REF;
        end else if (stale) begin
            o_verdict = V_STALE;
        end else if (ref_len_bad) begin
            o_verdict = V_WRONG_LEN;
        end else if (ref_mux_bad) begin
            o_verdict = V_REF_MUX;
        end else if (mask_bad) begin
            o_verdict = V_OUT_OF_MASK;
        end else begin
            o_verdict = V_OK;
        end
    end

endmodule

@@ hw/rtl/can_frame_mask_guard.sv @@
// ----------------------------------------------------------------------------
// can_frame_mask_guard
// judges each outgoing can frame against a fixed action table, one verdict per item
// ----------------------------------------------------------------------------
// Each input item carries an outgoing frame, the action it claims to perform
// and the reference frame last heard on the bus; one output item with an
// 8-bit tdata carries the verdict (0 ok, 1 no row, 2 bad args, 3 wrong id,
// 4 wrong length, 5 wrong mux, 6 no ref, 7 stale, 8 ref mux, 9 out of mask).
// The block takes one item per clock unless m_axis backpressure holds it;
// each item goes first into the input register, then the ordered checks and
// the 64-bit masked compare settle in one pass into the result register. The
// slowest path is the 32-bit wrapping age subtract and compare beside the
// 64-bit payload compare. The result register lets a new item enter while a
// verdict still waits; backpressure on m_axis stalls both stages once both are full.
// The freshness limit (reset 500 ms) sits at apb byte address 0 and should
// only be written while no item is in flight.
// ----------------------------------------------------------------------------
module can_frame_mask_guard #(
    parameter int P_IN_TDATA_W  = cfmg_pkg::IN_TDATA_W,
    parameter int P_OUT_TDATA_W = cfmg_pkg::OUT_TDATA_W
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input items
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // can_id, out_data, out_dlc, ref_seen, ref_data, ref_dlc, ref_ms, now_ms, zero pad
    input  logic [P_IN_TDATA_W-1:0]          s_axis_tdata,
    // action
    input  logic [cfmg_pkg::ACTION_W-1:0]    s_axis_tuser,
    // result items
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // verdict, zero pad
    output logic [P_OUT_TDATA_W-1:0]         m_axis_tdata,
    // apb configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cfmg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [cfmg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [cfmg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import cfmg_pkg::*;

    // tdata field offsets, lowest first
    localparam int OFS_OUT_DATA = ID_W;
    localparam int OFS_OUT_DLC  = OFS_OUT_DATA + DATA_W;
    localparam int OFS_SEEN     = OFS_OUT_DLC + DLC_W;
    localparam int OFS_REF_DATA = OFS_SEEN + 1;
    localparam int OFS_REF_DLC  = OFS_REF_DATA + DATA_W;
    localparam int OFS_REF_MS   = OFS_REF_DLC + DLC_W;
    localparam int OFS_NOW_MS   = OFS_REF_MS + MS_W;

    logic [FRESH_W-1:0] fresh_ms;

    t_frame   r_frame;
    t_frame   n_frame;
    logic     r_in_valid;
    logic     n_in_valid;
    t_verdict r_verdict;
    t_verdict n_verdict;
    logic     r_out_valid;
    logic     n_out_valid;
    t_verdict verdict;
    t_frame   in_frame;
    logic     out_adv;
    logic     in_take;

    cfmg_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_fresh_ms (fresh_ms)
    );

    // unpack the incoming item
    always_comb begin
        in_frame.action   = s_axis_tuser;
        in_frame.can_id   = s_axis_tdata[ID_W-1:0];
        in_frame.out_data = s_axis_tdata[OFS_OUT_DATA +: DATA_W];
        in_frame.out_dlc  = s_axis_tdata[OFS_OUT_DLC +: DLC_W];
        in_frame.ref_seen = s_axis_tdata[OFS_SEEN];
        in_frame.ref_data = s_axis_tdata[OFS_REF_DATA +: DATA_W];
        in_frame.ref_dlc  = s_axis_tdata[OFS_REF_DLC +: DLC_W];
        in_frame.ref_ms   = s_axis_tdata[OFS_REF_MS +: MS_W];
        in_frame.now_ms   = s_axis_tdata[OFS_NOW_MS +: MS_W];
    end

    cfmg_judge u_judge (
        .i_frame    (r_frame),
        .i_fresh_ms (fresh_ms),
        .o_verdict  (verdict)
    );

    // result register moves when empty or being drained
    assign out_adv       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || out_adv;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_frame     = r_frame;
        n_in_valid  = r_in_valid;
        n_verdict   = r_verdict;
        n_out_valid = r_out_valid;
        if (out_adv) begin
            n_out_valid = r_in_valid;
            n_in_valid  = 1'b0;
            if (r_in_valid) begin
                n_verdict = verdict;
            end
        end
        if (in_take) begin
            n_frame    = in_frame;
            n_in_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_frame   <= n_frame;
        r_verdict <= n_verdict;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(P_OUT_TDATA_W-VERDICT_W){1'b0}}, r_verdict};

endmodule

@@ tb/cfmg_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cfmg_checker
// watches the frame guard channels, predicts each verdict and compares
// ----------------------------------------------------------------------------
module cfmg_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [cfmg_pkg::IN_TDATA_W-1:0]  i_in_data,
    input  logic [cfmg_pkg::ACTION_W-1:0]    i_in_user,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [cfmg_pkg::OUT_TDATA_W-1:0] i_out_data,
    input  logic                             i_psel,
    input  logic                             i_penable,
    input  logic                             i_pwrite,
    input  logic [cfmg_pkg::APB_ADDR_W-1:0]  i_paddr,
    input  logic [cfmg_pkg::APB_DATA_W-1:0]  i_pwdata,
    input  logic                             i_pready,
    output int                               o_pending,
    output int                               o_mismatches
);
    import cfmg_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DLC_W-1:0]  len;
        logic [7:0]        mplx_mask;
        logic [7:0]        mplx_value;
        logic [DATA_W-1:0] payload;
    } t_guard_entry;

    t_verdict           verdict_q[$];
    logic [FRESH_W-1:0] fresh_lim;
    int                 mismatch_count = 0;

    initial begin
        fresh_lim = FRESH_RESET;
    end

    function automatic t_guard_entry entry_of(logic [ACTION_W-1:0] action);
        t_guard_entry e;
        case (action)
            4'd0:    e = {29'h273, 4'd8, 8'h00, 8'h00, 64'h0800000000000000};
            4'd1:    e = {29'h1F9, 4'd8, 8'h00, 8'h00, 64'h000000000000DB60};
            4'd2:    e = {29'h3C2, 4'd8, 8'hFF, 8'h29, 64'h0008000000000000};
            4'd3:    e = {29'h3C2, 4'd8, 8'hFF, 8'h00, 64'h0000000000000F00};
            4'd4:    e = {29'h3C2, 4'd8, 8'hFF, 8'h00, 64'h0000000000000000};
            4'd5:    e = {29'h3C2, 4'd8, 8'hFF, 8'h29, 64'h000000003F000000};
            4'd6:    e = {29'h229, 4'd3, 8'h00, 8'h00, 64'h000000000000FFFF};
            4'd7:    e = {29'h3E9, 4'd8, 8'h00, 8'h00, 64'hFFF0000000000004};
            4'd8:    e = {29'h273, 4'd8, 8'h00, 8'h00, 64'h0000000003000000};
            4'd9:    e = {29'h3C2, 4'd8, 8'h03, 8'h00, 64'h0000000000000004};
            4'd10:   e = {29'h249, 4'd4, 8'h00, 8'h00, 64'h00000000000EFFFF};
            default: e = '0;
        endcase
        return e;
    endfunction

    // first failing check decides
    function automatic t_verdict judge_frame(t_frame f, logic [FRESH_W-1:0] lim);
        t_guard_entry      e;
        logic [DATA_W-1:0] keep;
        logic [MS_W-1:0]   age;
        if (f.out_dlc > DLC_W'(MAX_FRAME_BYTES)) return V_BAD_ARGS;
        if (f.action >= ACTION_W'(ROW_COUNT)) return V_NO_ROW;
        e = entry_of(f.action);
        if (f.can_id != e.id) return V_WRONG_ID;
        if (f.out_dlc != e.len) return V_WRONG_LEN;
        if ((f.out_data[7:0] & e.mplx_mask) != e.mplx_value) return V_WRONG_MUX;
        if (!f.ref_seen) return V_NO_REF;
        age = f.now_ms - f.ref_ms;
        if (age >= MS_W'(lim)) return V_STALE;
        if (f.ref_dlc != e.len) return V_WRONG_LEN;
        if ((f.ref_data[7:0] & e.mplx_mask) != e.mplx_value) return V_REF_MUX;
        if (e.len >= DLC_W'(MAX_FRAME_BYTES)) begin
            keep = '1;
        end else begin
            keep = (DATA_W'(1) << (8 * e.len)) - DATA_W'(1);
        end
        keep = ~e.payload & keep;
        if ((f.out_data & keep) != (f.ref_data & keep)) return V_OUT_OF_MASK;
        return V_OK;
    endfunction

    task automatic flag_mismatch(string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_frame   f;
        t_verdict want;
        if (!i_rst_n) begin
            verdict_q.delete();
            fresh_lim = FRESH_RESET;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    flag_mismatch($sformatf("verdict %0d with none waiting", i_out_data));
                end else begin
                    want = verdict_q.pop_front();
                    if (i_out_data !== OUT_TDATA_W'(want)) begin
                        flag_mismatch($sformatf("verdict %0d, expected %0d",
                                                i_out_data, want));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                {f.now_ms, f.ref_ms, f.ref_dlc, f.ref_data, f.ref_seen,
                 f.out_dlc, f.out_data, f.can_id} = i_in_data[IN_FIELDS_W-1:0];
                f.action = i_in_user;
                verdict_q.push_back(judge_frame(f, fresh_lim));
            end
            // register write after the item so an item on the same edge sees the old limit
            if (i_psel && i_penable && i_pwrite && i_pready
                && i_paddr == {REG_FRESH_MS, 2'b00}) begin
                fresh_lim = i_pwdata[FRESH_W-1:0];
            end
        end
        o_pending    <= verdict_q.size();
        o_mismatches <= mismatch_count;
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// frame guard test: directed corner items then random phases per freshness limit
// ----------------------------------------------------------------------------
module testbench;
    import cfmg_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_ITEMS = 130;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [ACTION_W-1:0]    s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    int                 pending;
    int                 mismatches;
    int                 cycle_count = 0;
    logic [FRESH_W-1:0] cur_fresh   = FRESH_RESET;
    bit                 tx_idle_on  = 1'b1;
    bit                 rx_idle_on  = 1'b1;
    bit                 hold_req    = 1'b0;

    can_frame_mask_guard DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    cfmg_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    always #5 i_clk = ~i_clk;

    // run guard against a hung handshake
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // force byte 0 to carry the row's multiplex value under its mask
    function automatic logic [7:0] fix_mux(logic [7:0] b, logic [7:0] mask, logic [7:0] value);
        return (b & ~mask) | value;
    endfunction

    // any byte 0 that fails the multiplex check, mask must be non-zero
    function automatic logic [7:0] break_mux(logic [7:0] mask, logic [7:0] value);
        logic [7:0] b;
        do b = 8'($urandom); while ((b & mask) == value);
        return b;
    endfunction

    // a frame that passes every check, random content where the row allows it
    function automatic t_frame good_frame(logic [ACTION_W-1:0] action);
        t_row            r;
        t_frame          f;
        logic [MS_W-1:0] age;
        r            = row_of(action);
        f.action     = action;
        f.can_id     = ID_W'(r.id);
        f.out_dlc    = r.len;
        f.out_data   = {$urandom, $urandom};
        f.out_data[7:0] = fix_mux(f.out_data[7:0], r.mplx_mask, r.mplx_value);
        f.ref_seen   = 1'b1;
        f.ref_dlc    = r.len;
        // frozen bits copied from the outgoing frame, the rest free
        f.ref_data   = ({$urandom, $urandom} & ~r.frozen) | (f.out_data & r.frozen);
        f.ref_data[7:0] = fix_mux(f.ref_data[7:0], r.mplx_mask, r.mplx_value);
        f.now_ms     = $urandom;
        if (cur_fresh == 0) begin
            age = '0;
        end else if ($urandom_range(0, 7) == 0) begin
            age = MS_W'(cur_fresh) - 1;        // just inside the freshness window
        end else begin
            age = $urandom_range(0, cur_fresh - 1);
        end
        f.ref_ms = f.now_ms - age;
        return f;
    endfunction

    // well-formed frames, clean or with one or two faults, some pure noise
    function automatic t_frame random_frame();
        t_frame          f;
        t_row            r;
        int              kind;
        int              b;
        logic [MS_W-1:0] age;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            f.action   = ACTION_W'($urandom_range(0, 15));
            f.can_id   = ID_W'($urandom);
            f.out_data = {$urandom, $urandom};
            f.out_dlc  = DLC_W'($urandom_range(0, 15));
            f.ref_seen = 1'($urandom_range(0, 1));
            f.ref_data = {$urandom, $urandom};
            f.ref_dlc  = DLC_W'($urandom_range(0, 15));
            f.ref_ms   = $urandom;
            f.now_ms   = $urandom;
            return f;
        end
        f = good_frame(ACTION_W'($urandom_range(0, ROW_COUNT - 1)));
        r = row_of(f.action);
        if (kind >= 50) begin
            repeat ($urandom_range(1, 2)) begin
                case ($urandom_range(0, 9))
                    0: f.out_dlc = DLC_W'($urandom_range(MAX_FRAME_BYTES + 1, 15));
                    1: f.action = ACTION_W'($urandom_range(ROW_COUNT, 15));
                    2: begin
                        if ($urandom_range(0, 1)) begin
                            f.can_id ^= ID_W'(1) << $urandom_range(0, ID_W - 1);
                        end else begin
                            f.can_id = ID_W'($urandom);
                        end
                    end
                    3: do f.out_dlc = DLC_W'($urandom_range(0, MAX_FRAME_BYTES));
                       while (f.out_dlc == r.len);
                    4: if (r.mplx_mask != 0) begin
                        f.out_data[7:0] = break_mux(r.mplx_mask, r.mplx_value);
                    end
                    5: f.ref_seen = 1'b0;
                    6: begin
                        age = $urandom;
                        if (age < MS_W'(cur_fresh)) age = MS_W'(cur_fresh) + $urandom_range(0, 3);
                        f.ref_ms = f.now_ms - age;
                    end
                    7: f.ref_dlc = DLC_W'($urandom_range(0, 15));
                    8: if (r.mplx_mask != 0) begin
                        f.ref_data[7:0] = break_mux(r.mplx_mask, r.mplx_value);
                    end
                    default: begin
                        do b = $urandom_range(0, DATA_W - 1); while (!r.frozen[b]);
                        f.ref_data[b] = ~f.ref_data[b];
                    end
                endcase
            end
        end
        return f;
    endfunction

    // setup cycle, access cycle, deassert once pready has been seen
    task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // offer one item, optionally after an idle burst, and hold it until taken
    task automatic push_frame(t_frame f);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({f.now_ms, f.ref_ms, f.ref_dlc, f.ref_data, f.ref_seen,
                                      f.out_dlc, f.out_data, f.can_id});
        s_axis_tuser  <= f.action;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // stop offering and wait until every verdict has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic run_directed();
        t_frame f;
        // one clean item per row, rows without multiplex included
        for (int a = 0; a < ROW_COUNT; a++) begin
            push_frame(good_frame(ACTION_W'(a)));
        end
        // overlong frame wins over the missing row
        f = good_frame(4'd11);
        f.out_dlc = 4'd15;
        push_frame(f);
        // action without row
        f = good_frame(4'd15);
        f.out_dlc = 4'd8;
        push_frame(f);
        // overlong frame on a real row
        f = good_frame(4'd2);
        f.out_dlc = 4'd9;
        push_frame(f);
        // id matching in the low bits only
        f = good_frame(4'd0);
        f.can_id = 29'h1FFFF273;
        push_frame(f);
        // outgoing length wrong
        f = good_frame(4'd6);
        f.out_dlc = 4'd8;
        push_frame(f);
        // outgoing multiplex wrong
        f = good_frame(4'd2);
        f.out_data[7:0] = 8'h00;
        push_frame(f);
        // no reference heard
        f = good_frame(4'd1);
        f.ref_seen = 1'b0;
        push_frame(f);
        // age exactly at the limit is stale
        f = good_frame(4'd7);
        f.ref_ms = f.now_ms - MS_W'(cur_fresh);
        push_frame(f);
        // age one below the limit across the time wrap
        f = good_frame(4'd8);
        f.now_ms = 32'd5;
        f.ref_ms = f.now_ms - (MS_W'(cur_fresh) - 1);
        push_frame(f);
        // reference length mismatch gives the length code
        f = good_frame(4'd10);
        f.ref_dlc = 4'd8;
        push_frame(f);
        // reference multiplex wrong
        f = good_frame(4'd5);
        f.ref_data[7:0] = 8'h28;
        push_frame(f);
        // a frozen bit differs at the very top
        f = good_frame(4'd3);
        f.ref_data[63] = ~f.ref_data[63];
        push_frame(f);
        // bytes past the row length are ignored
        f = good_frame(4'd6);
        f.out_data[63:24] = '1;
        f.ref_data[63:24] = '0;
        push_frame(f);
        // data and time extremes on a row without multiplex
        f = good_frame(4'd7);
        f.out_data = '1;
        f.ref_data = '1;
        f.now_ms   = '1;
        f.ref_ms   = '1;
        push_frame(f);
        // all zeros and all ones
        f = '0;
        push_frame(f);
        f = '1;
        push_frame(f);
    endtask

    task automatic run_phase(logic [FRESH_W-1:0] fresh, bit idle, bit with_hold);
        drain();
        apb_write({REG_FRESH_MS, 2'b00}, APB_DATA_W'(fresh));
        cur_fresh  = fresh;
        tx_idle_on = idle;
        rx_idle_on = idle;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long receiver hold-off while items keep coming
            if (with_hold && n == PHASE_ITEMS / 3) hold_req = 1'b1;
            push_frame(random_frame());
        end
        drain();
    endtask

    // receiver: random stall bursts, plus the long hold-off on request
    initial begin : receiver
        m_axis_tready = 1'b0;
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset limit of 500 ms
        run_directed();
        // tightest limit: only age zero is fresh
        run_phase(16'd1, 1'b1, 1'b0);
        // widest limit, with the output held off for a while
        run_phase(16'hFFFF, 1'b1, 1'b1);
        // zero limit makes every reference stale
        run_phase(16'd0, 1'b1, 1'b0);
        run_phase(16'($urandom_range(1, 65535)), 1'b1, 1'b0);
        // back to the reset value, no idling on either side
        run_phase(FRESH_RESET, 1'b0, 1'b0);

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
